/* sv/assert_macros.svh */
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while reset is released
`define BTPC_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// property checked at every edge, reset included
`define BTPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/btpc_pkg.sv */
// ----------------------------------------------------------------------------
// btpc_pkg
// Types and constants of the barometric temperature and pressure compensation.
// ----------------------------------------------------------------------------
package btpc_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned DIV_STEPS   = 64;

    localparam int unsigned CFG_IDX_W = 8;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TEMP_COEFFS    = 8'd0;
    localparam t_cfg_idx CFG_PRESS_COEFFS_A = 8'd1;
    localparam t_cfg_idx CFG_PRESS_COEFFS_B = 8'd2;
    localparam t_cfg_idx CFG_PRESS_COEFF_9  = 8'd3;

    localparam logic [33:0] TFINE_OFFSET = 34'd128000;
    localparam logic [20:0] PRESS_BASE   = 21'd1048576;
    localparam logic [11:0] PRESS_SCALE  = 12'd3125;
    localparam logic [63:0] HALF_ONE_47  = 64'h0000_8000_0000_0000;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } t_coeffs;

    // one entry handed from the front part to the divider side
    typedef struct packed {
        logic signed [31:0] fine;
        logic signed [31:0] cent;
        logic        [63:0] num;
        logic        [63:0] den;
    } t_front_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic        [63:0] rem;
        logic        [63:0] quo;
        logic        [63:0] dsr;
        logic               neg;
        logic               ok;
        logic signed [31:0] fine;
        logic signed [31:0] cent;
    } t_div_st;

endpackage

/* sv/btpc_ifs.sv */
// ----------------------------------------------------------------------------
// btpc channel interfaces
// Sample input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface btpc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] adc_temperature;
    logic [19:0] adc_pressure;
    modport source (output valid, output adc_temperature, output adc_pressure, input ready);
    modport sink   (input valid, input adc_temperature, input adc_pressure, output ready);
endinterface

interface btpc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] fine_temperature;
    logic signed [31:0] temperature_centideg;
    logic        [31:0] pressure_q24_8;
    logic               pressure_valid;
    modport source (output valid, output fine_temperature, output temperature_centideg,
                    output pressure_q24_8, output pressure_valid, input ready);
    modport sink   (input valid, input fine_temperature, input temperature_centideg,
                    input pressure_q24_8, input pressure_valid, output ready);
endinterface

interface btpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [63:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/btpc_front.sv */
// ----------------------------------------------------------------------------
// btpc_front
// Temperature compensation and pressure numerator / denominator pipeline.
// ----------------------------------------------------------------------------
module btpc_front import btpc_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_coeffs        i_coef,
    btpc_in_if.sink        i_item,
    input  t_q_stat        i_qstat,
    output logic           o_push,
    output t_front_rec     o_rec
);

    logic [11:1] r_v;
    logic        en;

    assign en           = !(r_v[11] && i_qstat.full);
    assign i_item.ready = en;
    assign o_push       = r_v[11] && !i_qstat.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[10:1], i_item.valid};
        end
    end

    // stage 1
    logic signed [18:0] s1_ta;
    logic signed [17:0] s1_td;
    logic signed [34:0] s1_pa;
    logic signed [35:0] s1_pd;
    assign s1_ta = $signed({2'b00, i_item.adc_temperature[19:3]})
                 - $signed({2'b00, i_coef.t1, 1'b0});
    assign s1_td = $signed({2'b00, i_item.adc_temperature[19:4]})
                 - $signed({2'b00, i_coef.t1});
    assign s1_pa = s1_ta * $signed(i_coef.t2);
    assign s1_pd = s1_td * s1_td;

    logic [31:0] r1_a, r1_dd;
    logic [19:0] r1_adcp;

    // stage 2
    logic signed [31:0] s2_sh;
    logic signed [47:0] s2_pb;
    assign s2_sh = $signed(r1_dd) >>> 12;
    assign s2_pb = s2_sh * $signed(i_coef.t3);

    logic [31:0] r2_a, r2_b;
    logic [19:0] r2_adcp;

    // stage 3
    logic signed [31:0] s3_fa, s3_fb;
    assign s3_fa = $signed(r2_a) >>> 11;
    assign s3_fb = $signed(r2_b) >>> 14;

    logic signed [31:0] r3_fine;
    logic        [19:0] r3_adcp;

    // stage 4
    logic [31:0] s4_f5;
    assign s4_f5 = {r3_fine[29:0], 2'b00} + r3_fine + 32'd128;

    logic signed [31:0] r4_fine, r4_cent;
    logic signed [33:0] r4_v1;
    logic        [19:0] r4_adcp;

    // stage 5: v1 split in halves so the square stays in narrow multipliers
    logic signed [16:0] s5_vh;
    logic        [16:0] s5_vl;
    logic signed [33:0] s5_hh;
    logic signed [34:0] s5_hl;
    logic        [33:0] s5_ll;
    logic signed [49:0] s5_m5, s5_m2;
    assign s5_vh = r4_v1[33:17];
    assign s5_vl = r4_v1[16:0];
    assign s5_hh = s5_vh * s5_vh;
    assign s5_hl = s5_vh * $signed({1'b0, s5_vl});
    assign s5_ll = s5_vl * s5_vl;
    assign s5_m5 = r4_v1 * $signed(i_coef.p5);
    assign s5_m2 = r4_v1 * $signed(i_coef.p2);

    logic signed [31:0] r5_fine, r5_cent;
    logic signed [33:0] r5_hh;
    logic signed [34:0] r5_hl;
    logic        [33:0] r5_ll;
    logic signed [49:0] r5_m5, r5_m2;
    logic        [19:0] r5_adcp;

    // stage 6
    logic signed [31:0] r6_fine, r6_cent;
    logic        [63:0] r6_sq, r6_t5, r6_t2;
    logic        [19:0] r6_adcp;

    // stage 7
    logic signed [48:0] s7_l6, s7_h6, s7_l3, s7_h3;
    assign s7_l6 = $signed({1'b0, r6_sq[31:0]})  * $signed(i_coef.p6);
    assign s7_h6 = $signed({1'b0, r6_sq[63:32]}) * $signed(i_coef.p6);
    assign s7_l3 = $signed({1'b0, r6_sq[31:0]})  * $signed(i_coef.p3);
    assign s7_h3 = $signed({1'b0, r6_sq[63:32]}) * $signed(i_coef.p3);

    logic signed [31:0] r7_fine, r7_cent;
    logic signed [48:0] r7_l6, r7_l3;
    logic        [31:0] r7_h6, r7_h3;
    logic        [63:0] r7_t5, r7_t2;
    logic        [19:0] r7_adcp;

    // stage 8
    logic signed [31:0] r8_fine, r8_cent;
    logic        [63:0] r8_v2, r8_x3, r8_t2;
    logic        [19:0] r8_adcp;

    // stage 9
    logic [63:0] s9_v1b;
    logic [20:0] s9_pb;
    assign s9_v1b = 64'($signed(r8_x3) >>> 8) + r8_t2;
    assign s9_pb  = PRESS_BASE - {1'b0, r8_adcp};

    logic signed [31:0] r9_fine, r9_cent;
    logic        [63:0] r9_w, r9_nn;

    // stage 10
    logic [47:0] s10_wl, s10_wh;
    logic [43:0] s10_nl, s10_nh;
    assign s10_wl = r9_w[31:0]   * i_coef.p1;
    assign s10_wh = r9_w[63:32]  * i_coef.p1;
    assign s10_nl = r9_nn[31:0]  * PRESS_SCALE;
    assign s10_nh = r9_nn[63:32] * PRESS_SCALE;

    logic signed [31:0] r10_fine, r10_cent;
    logic        [47:0] r10_wl;
    logic        [31:0] r10_wh;
    logic        [43:0] r10_nl;
    logic        [31:0] r10_nh;

    // stage 11
    logic [63:0] s11_prod;
    assign s11_prod = {16'd0, r10_wl} + {r10_wh, 32'd0};

    t_front_rec r11_rec;
    assign o_rec = r11_rec;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_a     <= s1_pa[31:0];
            r1_dd    <= s1_pd[31:0];
            r1_adcp  <= i_item.adc_pressure;

            r2_a     <= r1_a;
            r2_b     <= s2_pb[31:0];
            r2_adcp  <= r1_adcp;

            r3_fine  <= s3_fa + s3_fb;
            r3_adcp  <= r2_adcp;

            r4_fine  <= r3_fine;
            r4_cent  <= $signed(s4_f5) >>> 8;
            r4_v1    <= $signed({{2{r3_fine[31]}}, r3_fine} - TFINE_OFFSET);
            r4_adcp  <= r3_adcp;

            r5_fine  <= r4_fine;
            r5_cent  <= r4_cent;
            r5_hh    <= s5_hh;
            r5_hl    <= s5_hl;
            r5_ll    <= s5_ll;
            r5_m5    <= s5_m5;
            r5_m2    <= s5_m2;
            r5_adcp  <= r4_adcp;

            r6_fine  <= r5_fine;
            r6_cent  <= r5_cent;
            r6_sq    <= (64'(r5_hh) << 34) + (64'(r5_hl) << 18) + 64'(r5_ll);
            r6_t5    <= 64'(r5_m5) << 17;
            r6_t2    <= 64'(r5_m2) << 12;
            r6_adcp  <= r5_adcp;

            r7_fine  <= r6_fine;
            r7_cent  <= r6_cent;
            r7_l6    <= s7_l6;
            r7_h6    <= s7_h6[31:0];
            r7_l3    <= s7_l3;
            r7_h3    <= s7_h3[31:0];
            r7_t5    <= r6_t5;
            r7_t2    <= r6_t2;
            r7_adcp  <= r6_adcp;

            r8_fine  <= r7_fine;
            r8_cent  <= r7_cent;
            r8_v2    <= 64'(r7_l6) + {r7_h6, 32'd0} + r7_t5
                      + (64'($signed(i_coef.p4)) << 35);
            r8_x3    <= 64'(r7_l3) + {r7_h3, 32'd0};
            r8_t2    <= r7_t2;
            r8_adcp  <= r7_adcp;

            r9_fine  <= r8_fine;
            r9_cent  <= r8_cent;
            r9_w     <= s9_v1b + HALF_ONE_47;
            r9_nn    <= {12'd0, s9_pb, 31'd0} - r8_v2;

            r10_fine <= r9_fine;
            r10_cent <= r9_cent;
            r10_wl   <= s10_wl;
            r10_wh   <= s10_wh[31:0];
            r10_nl   <= s10_nl;
            r10_nh   <= s10_nh[31:0];

            r11_rec.fine <= r10_fine;
            r11_rec.cent <= r10_cent;
            r11_rec.num  <= {20'd0, r10_nl} + {r10_nh, 32'd0};
            r11_rec.den  <= 64'($signed(s11_prod) >>> 33);
        end
    end

endmodule

/* sv/btpc_queue.sv */
// ----------------------------------------------------------------------------
// btpc_queue
// Short queue between the front pipeline and the divider side.
// ----------------------------------------------------------------------------
module btpc_queue import btpc_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_front_rec i_rec,
    input  logic       i_pop,
    output t_front_rec o_rec,
    output t_q_stat    o_stat
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    t_front_rec    r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;

    assign o_rec        = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == FULL_CNT);
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            priority if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

endmodule

/* sv/btpc_back.sv */
// ----------------------------------------------------------------------------
// btpc_back
// Pipelined signed 64-bit divider, pressure refinement and saturation.
// ----------------------------------------------------------------------------
module btpc_back import btpc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_coeffs    i_coef,
    input  t_q_stat    i_qstat,
    input  t_front_rec i_rec,
    output logic       o_pop,
    btpc_out_if.source o_res
);

    logic               en;
    logic [DIV_STEPS:0] r_dv;
    logic [5:0]         r_bv;
    logic               r_ov;

    assign en    = !(r_ov && !o_res.ready);
    assign o_pop = en && !i_qstat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
            r_bv <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_dv <= {r_dv[DIV_STEPS-1:0], o_pop};
            r_bv <= {r_bv[4:0], r_dv[DIV_STEPS]};
            r_ov <= r_bv[5];
        end
    end

    // divider entry: magnitudes and quotient sign
    logic        d0_na, d0_nb, d0_zero;
    logic [63:0] d0_ma, d0_mb;
    assign d0_na   = i_rec.num[63];
    assign d0_nb   = i_rec.den[63];
    assign d0_zero = (i_rec.den == '0);
    assign d0_ma   = d0_na ? (64'd0 - i_rec.num) : i_rec.num;
    assign d0_mb   = d0_zero ? 64'd1 : (d0_nb ? (64'd0 - i_rec.den) : i_rec.den);

    t_div_st r_d [DIV_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d[0].rem  <= '0;
            r_d[0].quo  <= d0_ma;
            r_d[0].dsr  <= d0_mb;
            r_d[0].neg  <= d0_na ^ d0_nb;
            r_d[0].ok   <= !d0_zero;
            r_d[0].fine <= i_rec.fine;
            r_d[0].cent <= i_rec.cent;
        end
    end

    // one quotient bit per stage, restoring
    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
        logic [64:0] trial;
        assign trial = {r_d[k-1].rem, r_d[k-1].quo[63]} - {1'b0, r_d[k-1].dsr};

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_d[k].rem  <= trial[64] ? {r_d[k-1].rem[62:0], r_d[k-1].quo[63]}
                                         : trial[63:0];
                r_d[k].quo  <= {r_d[k-1].quo[62:0], !trial[64]};
                r_d[k].dsr  <= r_d[k-1].dsr;
                r_d[k].neg  <= r_d[k-1].neg;
                r_d[k].ok   <= r_d[k-1].ok;
                r_d[k].fine <= r_d[k-1].fine;
                r_d[k].cent <= r_d[k-1].cent;
            end
        end
    end

    // post-division stages
    logic signed [31:0] r0_fine, r1_fine, r2_fine, r3_fine, r4_fine, r5_fine;
    logic signed [31:0] r0_cent, r1_cent, r2_cent, r3_cent, r4_cent, r5_cent;
    logic               r0_ok, r1_ok, r2_ok, r3_ok, r4_ok, r5_ok;
    logic        [63:0] r0_p, r1_p, r2_p, r3_p, r4_p;

    // square of p >> 13 and p8 term, split in 32-bit halves
    logic [63:0] b1_s;
    logic [63:0] b1_ll, b1_lh;
    logic signed [48:0] b1_l8, b1_h8;
    assign b1_s  = 64'($signed(r0_p) >>> 13);
    assign b1_ll = b1_s[31:0] * b1_s[31:0];
    assign b1_lh = b1_s[31:0] * b1_s[63:32];
    assign b1_l8 = $signed({1'b0, r0_p[31:0]})  * $signed(i_coef.p8);
    assign b1_h8 = $signed({1'b0, r0_p[63:32]}) * $signed(i_coef.p8);

    logic        [63:0] r1_ll;
    logic        [31:0] r1_lh, r1_h8;
    logic signed [48:0] r1_l8;

    logic [63:0] b2_w2;
    assign b2_w2 = 64'(r1_l8) + {r1_h8, 32'd0};

    logic [63:0] r2_ss, r2_w2;

    logic signed [48:0] b3_l9, b3_h9;
    assign b3_l9 = $signed({1'b0, r2_ss[31:0]})  * $signed(i_coef.p9);
    assign b3_h9 = $signed({1'b0, r2_ss[63:32]}) * $signed(i_coef.p9);

    logic signed [48:0] r3_l9;
    logic        [31:0] r3_h9;
    logic        [63:0] r3_w2;

    logic [63:0] b4_w1;
    assign b4_w1 = 64'(r3_l9) + {r3_h9, 32'd0};

    logic [63:0] r4_w1, r4_w2;

    logic [63:0] b5_sum;
    assign b5_sum = r4_p + r4_w1 + r4_w2;

    logic [63:0] r5_t;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_p    <= r_d[DIV_STEPS].neg ? (64'd0 - r_d[DIV_STEPS].quo) : r_d[DIV_STEPS].quo;
            r0_ok   <= r_d[DIV_STEPS].ok;
            r0_fine <= r_d[DIV_STEPS].fine;
            r0_cent <= r_d[DIV_STEPS].cent;

            r1_ll   <= b1_ll;
            r1_lh   <= b1_lh[31:0];
            r1_l8   <= b1_l8;
            r1_h8   <= b1_h8[31:0];
            r1_p    <= r0_p;
            r1_ok   <= r0_ok;
            r1_fine <= r0_fine;
            r1_cent <= r0_cent;

            r2_ss   <= r1_ll + {r1_lh[30:0], 1'b0, 32'd0};
            r2_w2   <= 64'($signed(b2_w2) >>> 19);
            r2_p    <= r1_p;
            r2_ok   <= r1_ok;
            r2_fine <= r1_fine;
            r2_cent <= r1_cent;

            r3_l9   <= b3_l9;
            r3_h9   <= b3_h9[31:0];
            r3_w2   <= r2_w2;
            r3_p    <= r2_p;
            r3_ok   <= r2_ok;
            r3_fine <= r2_fine;
            r3_cent <= r2_cent;

            r4_w1   <= 64'($signed(b4_w1) >>> 25);
            r4_w2   <= r3_w2;
            r4_p    <= r3_p;
            r4_ok   <= r3_ok;
            r4_fine <= r3_fine;
            r4_cent <= r3_cent;

            r5_t    <= 64'($signed(b5_sum) >>> 8) + (64'($signed(i_coef.p7)) << 4);
            r5_ok   <= r4_ok;
            r5_fine <= r4_fine;
            r5_cent <= r4_cent;
        end
    end

    // output register with saturation
    logic [31:0] r_press;
    logic        r_pvalid;
    logic signed [31:0] r_ofine, r_ocent;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ofine  <= r5_fine;
            r_ocent  <= r5_cent;
            r_pvalid <= r5_ok;
            priority if (!r5_ok || r5_t[63]) begin
                r_press <= 32'd0;
            end else if (r5_t[62:32] != '0) begin
                r_press <= 32'hFFFF_FFFF;
            end else begin
                r_press <= r5_t[31:0];
            end
        end
    end

    assign o_res.valid                = r_ov;
    assign o_res.fine_temperature     = r_ofine;
    assign o_res.temperature_centideg = r_ocent;
    assign o_res.pressure_q24_8       = r_press;
    assign o_res.pressure_valid       = r_pvalid;

endmodule

/* sv/baro_temp_pressure_compensation_core.sv */
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_core
// Integer temperature and 64-bit pressure compensation of raw sensor readings.
// ----------------------------------------------------------------------------
// Takes one sample (raw temperature and pressure) per clock when nothing
// stalls and returns one result per sample, in order. A sample passes the
// front pipeline, a queue entry, the divider entry register, a 64-stage
// radix-2 divider, one quotient bit per stage, and 7 refinement and output
// stages.
// Coefficients are written through the configuration channel, which is
// always ready; write them only while no sample is in flight.
module baro_temp_pressure_compensation_core import btpc_pkg::*; #(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    btpc_in_if.sink    i_item,
    btpc_cfg_if.sink   i_cfg,
    btpc_out_if.source o_result
);

    logic [47:0] r_temp_coeffs;
    logic [63:0] r_press_a, r_press_b;
    logic [15:0] r_p9;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coeffs <= '0;
            r_press_a     <= '0;
            r_press_b     <= '0;
            r_p9          <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_TEMP_COEFFS:    r_temp_coeffs <= i_cfg.data[47:0];
                CFG_PRESS_COEFFS_A: r_press_a     <= i_cfg.data;
                CFG_PRESS_COEFFS_B: r_press_b     <= i_cfg.data;
                CFG_PRESS_COEFF_9:  r_p9          <= i_cfg.data[15:0];
                default: begin
                end
            endcase
        end
    end

    t_coeffs coef;
    assign coef.t1 = r_temp_coeffs[15:0];
    assign coef.t2 = r_temp_coeffs[31:16];
    assign coef.t3 = r_temp_coeffs[47:32];
    assign coef.p1 = r_press_a[15:0];
    assign coef.p2 = r_press_a[31:16];
    assign coef.p3 = r_press_a[47:32];
    assign coef.p4 = r_press_a[63:48];
    assign coef.p5 = r_press_b[15:0];
    assign coef.p6 = r_press_b[31:16];
    assign coef.p7 = r_press_b[47:32];
    assign coef.p8 = r_press_b[63:48];
    assign coef.p9 = r_p9;

    logic       push, pop;
    t_front_rec push_rec, pop_rec;
    t_q_stat    qstat;

    btpc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (coef),
        .i_item  (i_item),
        .i_qstat (qstat),
        .o_push  (push),
        .o_rec   (push_rec)
    );

    btpc_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_rec   (pop_rec),
        .o_stat  (qstat)
    );

    btpc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_coef  (coef),
        .i_qstat (qstat),
        .i_rec   (pop_rec),
        .o_pop   (pop),
        .o_res   (o_result)
    );

endmodule

/* sv/btpc_checker.sv */
// ----------------------------------------------------------------------------
// btpc_checker
// Port-level checks of the compensation core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module btpc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [31:0] i_fine,
    input logic signed [31:0] i_cent,
    input logic        [31:0] i_press,
    input logic               i_pvalid
);

    logic [31:0]        f5;
    logic signed [31:0] exp_cent;
    assign f5       = {i_fine[29:0], 2'b00} + i_fine + 32'd128;
    assign exp_cent = $signed(f5) >>> 8;

    `BTPC_ASSERT_RST(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped while stalled")
    `BTPC_ASSERT_RST(a_bad_press_zero, i_clk, i_rst_n, i_out_valid && !i_pvalid |-> i_press == 32'd0, "invalid pressure not zero")
    `BTPC_ASSERT_RST(a_cent_match, i_clk, i_rst_n, i_out_valid |-> i_cent == exp_cent, "centidegree disagrees with fine temperature")
    `BTPC_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

endmodule

bind baro_temp_pressure_compensation_core btpc_checker u_btpc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_fine      (o_result.fine_temperature),
    .i_cent      (o_result.temperature_centideg),
    .i_press     (o_result.pressure_q24_8),
    .i_pvalid    (o_result.pressure_valid)
);
